// ===== sv/mvm_pkg.sv =====
`timescale 1ns / 1ps
// mvm_pkg: shared types, constants and arithmetic helpers for the
// matrix-vector multiply block. No dependencies.
package mvm_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COLCFG_W   = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic REQ_VECTOR = 1'b0;
  localparam logic REQ_MATRIX = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 8'd1;

  typedef struct packed {
    logic             size_error;
    logic             first;
    logic             row_end;
    logic             last_row;
    logic [ROW_W-1:0] row_index;
  } ctl_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    begin
      s = a + b;
      if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
        s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return s;
    end
  endfunction

endpackage

// ===== sv/mvm_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the matrix-vector multiply block: request words,
// result words and configuration writes. Depends on mvm_pkg.
interface mvm_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic signed [mvm_pkg::VAL_W-1:0]   element_value;

  modport source (output valid, req_type, element_value, input ready);
  modport sink   (input valid, req_type, element_value, output ready);
endinterface

interface mvm_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [mvm_pkg::SUM_W-1:0]   row_sum;
  logic        [mvm_pkg::ROW_W-1:0]   row_index;
  logic                               last_row;
  logic                               size_error;

  modport source (output valid, row_sum, row_index, last_row, size_error, input ready);
  modport sink   (input valid, row_sum, row_index, last_row, size_error, output ready);
endinterface

interface mvm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mvm_pkg::CFG_IDX_W-1:0]      reg_index;
  logic [mvm_pkg::CFG_DATA_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/mvm_ram.sv =====
`timescale 1ns / 1ps
// mvm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mvm_front.sv =====
`timescale 1ns / 1ps
// mvm_front: config registers, load/column/row tracking, vector store and
// the input stage register. Depends on mvm_pkg and mvm_ram.
module mvm_front #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic signed [mvm_pkg::VAL_W-1:0]   element_value_i,
  output logic                               s1_valid_o,
  input  logic                               s1_ready_i,
  output mvm_pkg::ctl_t                      s1_ctl_o,
  output logic signed [mvm_pkg::VAL_W-1:0]   s1_value_o,
  output logic signed [mvm_pkg::VAL_W-1:0]   s1_vec_o
);

  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);

  logic [mvm_pkg::COLCFG_W-1:0] col_count_q;
  logic [mvm_pkg::ROW_W-1:0]    row_count_q;
  logic [CNT_W-1:0]             loaded_q, loaded_d;
  logic [ADDR_W-1:0]            col_pos_q;
  logic [mvm_pkg::ROW_W-1:0]    row_pos_q;
  logic                         s1_valid_q;
  mvm_pkg::ctl_t                s1_ctl_q, ctl_d;
  logic signed [mvm_pkg::VAL_W-1:0] s1_value_q;

  logic [31:0]       cc_ext, eff_ext;
  logic [CNT_W-1:0]  eff_cols;
  logic              accept, is_load, load_full, size_err, row_end, last_row;
  logic [ADDR_W-1:0] waddr;
  logic [mvm_pkg::VAL_W-1:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= mvm_pkg::COLCFG_W'(1);
      row_count_q <= mvm_pkg::ROW_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mvm_pkg::REG_COLUMN_COUNT: col_count_q <= cfg_wdata_i[mvm_pkg::COLCFG_W-1:0];
        mvm_pkg::REG_ROW_COUNT:    row_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cc_ext  = 32'(col_count_q);
    eff_ext = cc_ext;
    if (cc_ext == 32'd0) begin
      eff_ext = 32'd1;
    end else if (cc_ext > 32'(MAX_LEN)) begin
      eff_ext = 32'(MAX_LEN);
    end
    eff_cols = CNT_W'(eff_ext);
  end

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = (req_type_i == mvm_pkg::REQ_VECTOR);
  assign load_full  = (loaded_q >= eff_cols);
  assign waddr      = load_full ? '0 : loaded_q[ADDR_W-1:0];
  assign loaded_d   = load_full ? CNT_W'(1) : loaded_q + CNT_W'(1);
  assign size_err   = (loaded_q < eff_cols);
  assign row_end    = ((CNT_W'(col_pos_q) + CNT_W'(1)) >= eff_cols);
  assign last_row   = (row_pos_q == (row_count_q - mvm_pkg::ROW_W'(1)));

  always_comb begin
    ctl_d.size_error = size_err;
    ctl_d.first      = (col_pos_q == '0);
    ctl_d.row_end    = row_end;
    ctl_d.last_row   = !size_err && last_row;
    ctl_d.row_index  = row_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= accept && !is_load;
      end
      if (accept) begin
        if (is_load) begin
          loaded_q  <= loaded_d;
          col_pos_q <= '0;
          row_pos_q <= '0;
        end else if (!size_err) begin
          if (row_end) begin
            col_pos_q <= '0;
            row_pos_q <= last_row ? '0 : row_pos_q + mvm_pkg::ROW_W'(1);
          end else begin
            col_pos_q <= col_pos_q + ADDR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_load) begin
      s1_ctl_q   <= ctl_d;
      s1_value_q <= element_value_i;
    end
  end

  mvm_ram #(
    .WIDTH (mvm_pkg::VAL_W),
    .DEPTH (MAX_LEN)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (accept && !is_load),
    .raddr_i (col_pos_q),
    .rdata_o (rdata)
  );

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = s1_ctl_q;
  assign s1_value_o = s1_value_q;
  assign s1_vec_o   = rdata;

endmodule

// ===== sv/mvm_mac.sv =====
`timescale 1ns / 1ps
// mvm_mac: product stage, saturating row accumulator and result register.
// Depends on mvm_pkg.
module mvm_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s1_valid_i,
  output logic                               s1_ready_o,
  input  mvm_pkg::ctl_t                      s1_ctl_i,
  input  logic signed [mvm_pkg::VAL_W-1:0]   s1_value_i,
  input  logic signed [mvm_pkg::VAL_W-1:0]   s1_vec_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mvm_pkg::SUM_W-1:0]   row_sum_o,
  output logic [mvm_pkg::ROW_W-1:0]          row_index_o,
  output logic                               last_row_o,
  output logic                               size_error_o
);

  logic                             s2_valid_q;
  mvm_pkg::ctl_t                    s2_ctl_q;
  logic signed [mvm_pkg::SUM_W-1:0] s2_prod_q;
  logic signed [mvm_pkg::SUM_W-1:0] acc_q, acc_d, acc_base;
  logic                             out_valid_q;
  logic signed [mvm_pkg::SUM_W-1:0] row_sum_q;
  logic [mvm_pkg::ROW_W-1:0]        row_index_q;
  logic                             last_row_q, size_error_q;
  logic                             out_free, s2_adv, s2_load, emit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_load    = !s2_valid_q || s2_adv;
  assign s1_ready_o = s2_load;
  assign emit       = s2_ctl_q.size_error || s2_ctl_q.row_end;

  assign acc_base = s2_ctl_q.first ? '0 : acc_q;
  assign acc_d    = mvm_pkg::sat_add(acc_base, s2_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid_q <= s1_valid_i;
      end
      if (s2_adv) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_i) begin
      s2_ctl_q  <= s1_ctl_i;
      s2_prod_q <= s1_value_i * s1_vec_i;
    end
    if (s2_adv && !s2_ctl_q.size_error) begin
      acc_q <= acc_d;
    end
    if (s2_adv && emit) begin
      row_sum_q    <= s2_ctl_q.size_error ? '0 : acc_d;
      row_index_q  <= s2_ctl_q.row_index;
      last_row_q   <= s2_ctl_q.last_row;
      size_error_q <= s2_ctl_q.size_error;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_sum_o    = row_sum_q;
  assign row_index_o  = row_index_q;
  assign last_row_o   = last_row_q;
  assign size_error_o = size_error_q;

endmodule

// ===== sv/matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// Streaming matrix-vector multiply in Q16.16 with a saturated Q32.32 row sum.
// Load the vector first (req_type 0, one element per word, column_count words),
// then stream the matrix row-major (req_type 1); each row yields one result
// word with its row index, and a matrix word seen before the vector is complete
// yields a size_error word. Throughput is one word per cycle for loads and matrix
// elements alike while the result side is not stalled; a result word passes the input
// register with vector RAM read, the product register, then the accumulator/result
// register before it is presented.
// Vector loads give no result. Write configuration only while the block is idle.
// Depends on mvm_pkg, mvm_if, mvm_front and mvm_mac.
module matrix_vector_multiply #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mvm_req_if.sink       req_i,
  mvm_res_if.source     res_o,
  mvm_cfg_if.sink       cfg_i
);

  logic                             s1_valid, s1_ready;
  mvm_pkg::ctl_t                    s1_ctl;
  logic signed [mvm_pkg::VAL_W-1:0] s1_value, s1_vec;

  assign cfg_i.ready = 1'b1;

  mvm_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.reg_index),
    .cfg_wdata_i     (cfg_i.wdata),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .req_type_i      (req_i.req_type),
    .element_value_i (req_i.element_value),
    .s1_valid_o      (s1_valid),
    .s1_ready_i      (s1_ready),
    .s1_ctl_o        (s1_ctl),
    .s1_value_o      (s1_value),
    .s1_vec_o        (s1_vec)
  );

  mvm_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_ready_o   (s1_ready),
    .s1_ctl_i     (s1_ctl),
    .s1_value_i   (s1_value),
    .s1_vec_i     (s1_vec),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .row_sum_o    (res_o.row_sum),
    .row_index_o  (res_o.row_index),
    .last_row_o   (res_o.last_row),
    .size_error_o (res_o.size_error)
  );

endmodule

// ===== sv/mvm_checker.sv =====
`timescale 1ns / 1ps
// mvm_checker: port-level assertions for matrix_vector_multiply, attached by
// bind. Depends on mvm_pkg and mvm_if.
module mvm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               req_ready_i,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic signed [mvm_pkg::SUM_W-1:0]   row_sum_i,
  input logic [mvm_pkg::ROW_W-1:0]          row_index_i,
  input logic                               last_row_i,
  input logic                               size_error_i
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(row_sum_i)
      && $stable(row_index_i) && $stable(last_row_i) && $stable(size_error_i))
    else $error("result word changed while stalled");

  // error words carry no sum and never close the matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && size_error_i |-> (row_sum_i == '0) && !last_row_i)
    else $error("size error word with sum or last_row set");

  // input back-pressure only comes from a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .row_sum_i    (res_o.row_sum),
  .row_index_i  (res_o.row_index),
  .last_row_i   (res_o.last_row),
  .size_error_i (res_o.size_error)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for matrix_vector_multiply. Streams vector and
// matrix words with random gaps and result back-pressure, predicts each row sum.
// Depends on mvm_pkg, mvm_if and the matrix_vector_multiply RTL.
module tb_top;

  localparam int unsigned VEC_DEPTH    = 64;
  localparam int unsigned VEC_AW       = $clog2(VEC_DEPTH);
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned DIRECTED_WORDS = 25;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned LONG_HOLD    = 400;

  typedef struct packed {
    logic                             req_type;
    logic signed [mvm_pkg::VAL_W-1:0] value;
  } elem_word_t;

  typedef struct packed {
    logic signed [mvm_pkg::SUM_W-1:0] row_sum;
    logic [mvm_pkg::ROW_W-1:0]        row_index;
    logic                             last_row;
    logic                             size_error;
  } row_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mvm_req_if req_bus();
  mvm_res_if res_bus();
  mvm_cfg_if cfg_bus();

  matrix_vector_multiply #(.MAX_LEN(VEC_DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  elem_word_t  pending_words[$];
  row_result_t expected_rows[$];

  // predictor state
  logic [mvm_pkg::COLCFG_W-1:0]     column_count_q = 1;
  logic [mvm_pkg::ROW_W-1:0]        row_count_q    = 1;
  logic signed [mvm_pkg::VAL_W-1:0] vector_mem [VEC_DEPTH];
  int unsigned                      loaded_cnt = 0;
  int unsigned                      col_pos    = 0;
  logic [mvm_pkg::ROW_W-1:0]        row_pos    = '0;
  logic signed [mvm_pkg::SUM_W-1:0] row_acc    = '0;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned words_queued = 0;
  logic        word_taken   = 1'b0;

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  rx_mode_e    rx_mode    = RX_OPEN;
  logic [7:0]  rx_mask    = 8'hff;
  int unsigned mode_left  = 0;
  int unsigned rx_phase   = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;
  int unsigned next_hold_at = 20;

  function automatic int unsigned active_columns(
    input logic [mvm_pkg::COLCFG_W-1:0] cols
  );
    if (cols == 0) return 1;
    if (cols > VEC_DEPTH) return VEC_DEPTH;
    return cols;
  endfunction

  function automatic bit mac_row(input elem_word_t w, output row_result_t r);
    int unsigned                      cols;
    int unsigned                      idx;
    logic signed [mvm_pkg::VAL_W-1:0] a;
    logic signed [mvm_pkg::VAL_W-1:0] b;
    logic signed [mvm_pkg::SUM_W-1:0] prod;
    logic signed [mvm_pkg::SUM_W:0]   wide;
    logic [mvm_pkg::ROW_W-1:0]        last_idx;
    logic                             last;
    cols = active_columns(column_count_q);
    r = '0;
    if (w.req_type == mvm_pkg::REQ_VECTOR) begin
      if (loaded_cnt >= cols) loaded_cnt = 0;
      vector_mem[VEC_AW'(loaded_cnt)] = w.value;
      loaded_cnt++;
      row_acc = '0;
      col_pos = 0;
      row_pos = '0;
      return 1'b0;
    end
    if (loaded_cnt < cols) begin
      r.row_index  = row_pos;
      r.size_error = 1'b1;
      return 1'b1;
    end
    idx  = (col_pos >= VEC_DEPTH) ? VEC_DEPTH - 1 : col_pos;
    a    = w.value;
    b    = vector_mem[VEC_AW'(idx)];
    prod = a * b;
    wide = (mvm_pkg::SUM_W+1)'(row_acc) + (mvm_pkg::SUM_W+1)'(prod);
    if (wide[mvm_pkg::SUM_W] != wide[mvm_pkg::SUM_W-1])
      row_acc = wide[mvm_pkg::SUM_W] ? {1'b1, {(mvm_pkg::SUM_W-1){1'b0}}}
                                     : {1'b0, {(mvm_pkg::SUM_W-1){1'b1}}};
    else
      row_acc = wide[mvm_pkg::SUM_W-1:0];
    if (col_pos + 1 >= cols) begin
      last_idx    = row_count_q - 1'b1;
      last        = (row_pos == last_idx);
      r.row_sum   = row_acc;
      r.row_index = row_pos;
      r.last_row  = last;
      row_acc     = '0;
      col_pos     = 0;
      row_pos     = last ? '0 : row_pos + 1'b1;
      return 1'b1;
    end
    col_pos++;
    return 1'b0;
  endfunction

  // word driver
  always @(negedge clk_i) begin : drive_words
    elem_word_t w;
    if (rst_ni) begin
      if (!req_bus.valid || word_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          req_bus.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          req_bus.valid         <= 1'b1;
          req_bus.req_type      <= w.req_type;
          req_bus.element_value <= w.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold while a result waits and words keep coming
  always @(posedge clk_i) begin : long_hold
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < 3 && results_seen >= next_hold_at && res_bus.valid &&
                   pending_words.size() > 8) begin
        hold_left    = LONG_HOLD;
        holds_done++;
        next_hold_at = results_seen + 120;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        rx_mask   = 8'($urandom_range(1, 255));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      rx_phase++;
      if (hold_left > 0) begin
        res_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   res_bus.ready <= 1'b1;
          RX_RANDOM: res_bus.ready <= ($urandom_range(0, 3) != 0);
          default:   res_bus.ready <= rx_mask[rx_phase % 8];
        endcase
      end
    end
  end

  // sample handshakes, predict and compare
  always @(posedge clk_i) begin : check_rows
    row_result_t got;
    row_result_t want;
    row_result_t pred;
    if (rst_ni) begin
      word_taken <= req_bus.valid && req_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.reg_index)
          mvm_pkg::REG_COLUMN_COUNT:
            column_count_q = cfg_bus.wdata[mvm_pkg::COLCFG_W-1:0];
          mvm_pkg::REG_ROW_COUNT:
            row_count_q    = cfg_bus.wdata;
          default: ;
        endcase
      end
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        got.row_sum    = res_bus.row_sum;
        got.row_index  = res_bus.row_index;
        got.last_row   = res_bus.last_row;
        got.size_error = res_bus.size_error;
        if (expected_rows.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("unexpected result word: sum %h row %0d last %0b err %0b",
                     got.row_sum, got.row_index, got.last_row, got.size_error);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            if (mismatches < MAX_SHOWN)
              $display("row mismatch: want sum %h row %0d last %0b err %0b, %s",
                       want.row_sum, want.row_index, want.last_row, want.size_error,
                       $sformatf("got sum %h row %0d last %0b err %0b",
                                 got.row_sum, got.row_index, got.last_row,
                                 got.size_error));
            mismatches++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        if (mac_row({req_bus.req_type, req_bus.element_value}, pred))
          expected_rows.push_back(pred);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic rt, input logic signed [mvm_pkg::VAL_W-1:0] v);
    elem_word_t w;
    w.req_type = rt;
    w.value    = v;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic signed [mvm_pkg::VAL_W-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return ($urandom_range(0, 1) != 0) ? -$urandom_range(0, 32'h3ffff)
                                                  : $urandom_range(0, 32'h3ffff);
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || req_bus.valid || expected_rows.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    @(negedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= mvm_pkg::CFG_DATA_W'(data);
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned cols, input int unsigned rows);
    settle();
    write_reg(mvm_pkg::REG_COLUMN_COUNT, cols);
    write_reg(mvm_pkg::REG_ROW_COUNT, rows);
  endtask

  initial begin : stimulus
    int unsigned cols_w;
    int unsigned rows_w;
    int unsigned cols;
    int unsigned rows;
    int unsigned nmat;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = mvm_pkg::REQ_VECTOR;
    req_bus.element_value = '0;
    res_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.reg_index     = mvm_pkg::REG_COLUMN_COUNT;
    cfg_bus.wdata         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    configure(1, 1);
    push_word(mvm_pkg::REQ_MATRIX, 32'h0001_0000);    // nothing loaded yet
    push_word(mvm_pkg::REQ_VECTOR, 32'h7fff_ffff);
    push_word(mvm_pkg::REQ_MATRIX, 32'h7fff_ffff);
    push_word(mvm_pkg::REQ_VECTOR, 32'h8000_0000);    // full vector, restarts at entry 0
    push_word(mvm_pkg::REQ_MATRIX, 32'h8000_0000);

    configure(2, 3);
    push_word(mvm_pkg::REQ_VECTOR, 32'h8000_0000);
    push_word(mvm_pkg::REQ_MATRIX, 32'h8000_0000);    // positive saturation
    push_word(mvm_pkg::REQ_MATRIX, 32'h8000_0000);
    push_word(mvm_pkg::REQ_MATRIX, 32'h7fff_ffff);
    push_word(mvm_pkg::REQ_MATRIX, 32'h7fff_ffff);
    push_word(mvm_pkg::REQ_MATRIX, 32'h0000_0000);
    push_word(mvm_pkg::REQ_MATRIX, 32'hffff_ffff);
    push_word(mvm_pkg::REQ_MATRIX, 32'h1234_5678);    // partial row dropped by the load
    push_word(mvm_pkg::REQ_VECTOR, 32'h0001_0000);
    push_word(mvm_pkg::REQ_MATRIX, 32'hdead_beef);
    push_word(mvm_pkg::REQ_VECTOR, 32'hffff_0000);

    configure(0, 0);                                  // zero columns act as one
    push_word(mvm_pkg::REQ_MATRIX, 32'h0001_0000);
    push_word(mvm_pkg::REQ_MATRIX, 32'h7fff_0000);

    configure(3, 2);
    repeat (3) push_word(mvm_pkg::REQ_VECTOR, 32'h7fff_ffff);
    repeat (3) push_word(mvm_pkg::REQ_MATRIX, 32'h8000_0000);  // reload wraps, still short

    configure(64, 65535);
    push_word(mvm_pkg::REQ_MATRIX, 32'h0000_0001);

    while (words_queued < DIRECTED_WORDS + RANDOM_WORDS) begin
      case ($urandom_range(0, 19))
        0:       cols_w = 0;
        1:       cols_w = 64;
        2:       cols_w = 127;
        3:       cols_w = $urandom_range(65, 126);
        default: cols_w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 7))
        0:       rows_w = 0;
        1:       rows_w = 65535;
        2:       rows_w = $urandom_range(6, 65534);
        default: rows_w = $urandom_range(1, 5);
      endcase
      configure(cols_w, rows_w);
      cols = active_columns(mvm_pkg::COLCFG_W'(cols_w));
      rows = (rows_w == 0 || rows_w > 5) ? 3 : rows_w;
      if (cols > 8 && rows > 2) rows = 2;
      if ($urandom_range(0, 5) == 0) push_word(mvm_pkg::REQ_MATRIX, rand_element());
      if ($urandom_range(0, 5) != 0)
        for (int i = 0; i < cols; i++) push_word(mvm_pkg::REQ_VECTOR, rand_element());
      nmat = (cols > 8) ? 1 : $urandom_range(1, 3);
      for (int m = 0; m < nmat; m++)
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) begin
            if ($urandom_range(0, 39) == 0) push_word(mvm_pkg::REQ_VECTOR, rand_element());
            push_word(mvm_pkg::REQ_MATRIX, rand_element());
          end
      // leave a row open so the next settings start mid-row
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) push_word(mvm_pkg::REQ_MATRIX, rand_element());
    end

    settle();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== matrix_vector_multiply.f =====
sv/mvm_pkg.sv
sv/mvm_if.sv
sv/mvm_ram.sv
sv/mvm_front.sv
sv/mvm_mac.sv
sv/matrix_vector_multiply.sv
sv/mvm_checker.sv
test/tb_top.sv
